### design/fw3_pkg.sv
`default_nettype none
package fw3_pkg;

    // Cube geometry; the coordinate fields are five bits wide, so the maximum side is fixed here.
    localparam int MAX_SIDE = 32;
    localparam int COORD_W  = 5;
    localparam int SIDE_W   = 6;
    localparam int ITER_W   = 7;
    localparam int ADDR_W   = 3 * COORD_W;
    localparam int DEPTH    = MAX_SIDE * MAX_SIDE * MAX_SIDE;
    localparam int CELL_W   = 64;
    localparam int VALUE_W  = 32;
    localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(MAX_SIDE);

    // Operation codes carried in the mode field.
    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SETUP,
        S_RD,
        S_WR,
        S_OUT
    } state_t;

    // One classified word as it travels from the front to the back.
    typedef struct packed {
        logic                      mode;
        logic [COORD_W-1:0]        xl;
        logic [COORD_W-1:0]        yl;
        logic [COORD_W-1:0]        zl;
        logic [COORD_W-1:0]        xh;
        logic [COORD_W-1:0]        yh;
        logic [COORD_W-1:0]        zh;
        logic signed [VALUE_W-1:0] value;
        logic [SIDE_W-1:0]         side;
    } cmd_t;

    // Status reported by the back to the front.
    typedef struct packed {
        logic clearing;
    } back_status_t;

    // Next index on the update chain, i | (i + 1).
    function automatic logic [ITER_W-1:0] next_up(input logic [ITER_W-1:0] v);
        return v | (v + ITER_W'(1));
    endfunction

    // Next index on the prefix chain, (i & (i + 1)) - 1.
    function automatic logic [ITER_W-1:0] next_down(input logic [ITER_W-1:0] v);
        return (v & (v + ITER_W'(1))) - ITER_W'(1);
    endfunction

    // An index is live while below the side on update, or non-negative on query.
    function automatic logic idx_live(input logic [ITER_W-1:0] v, input logic mode,
                                      input logic [SIDE_W-1:0] side);
        logic r;
        if (mode == MODE_ADD)
            r = (v < {1'b0, side});
        else
            r = ~v[ITER_W-1];
        return r;
    endfunction

endpackage
`default_nettype wire

### design/fw3_ifs.sv
`default_nettype none
interface fw3_in_if import fw3_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic [COORD_W-1:0]        x_low;
    logic [COORD_W-1:0]        y_low;
    logic [COORD_W-1:0]        z_low;
    logic [COORD_W-1:0]        x_high;
    logic [COORD_W-1:0]        y_high;
    logic [COORD_W-1:0]        z_high;
    logic signed [VALUE_W-1:0] add_value;
    modport source (output valid, mode, x_low, y_low, z_low, x_high, y_high, z_high,
                    add_value, input ready);
    modport sink   (input valid, mode, x_low, y_low, z_low, x_high, y_high, z_high,
                    add_value, output ready);
endinterface

interface fw3_out_if import fw3_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [CELL_W-1:0] box_sum;
    modport source (output valid, box_sum, input ready);
    modport sink   (input valid, box_sum, output ready);
endinterface

interface fw3_cfg_if import fw3_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SIDE_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

### design/fw3_front.sv
`default_nettype none
module fw3_front import fw3_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    fw3_in_if.sink            items,
    fw3_cfg_if.sink           cfg,
    input  wire back_status_t status,
    output logic              push_valid,
    input  wire logic         push_ready,
    output cmd_t              push_cmd
);

    logic [SIDE_W-1:0]  side_reg;
    logic [SIDE_W-1:0]  side_eff;
    logic [COORD_W-1:0] top_idx;

    function automatic logic [COORD_W-1:0] clamp(input logic [COORD_W-1:0] c,
                                                 input logic [COORD_W-1:0] t);
        return (c > t) ? t : c;
    endfunction

    // Side length register; writes are always taken.
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_reg <= SIDE_RESET;
        else if (cfg.valid)
            side_reg <= cfg.data;
    end

    // A side of zero acts as one and anything above the maximum as the maximum.
    always_comb
    begin
        if (side_reg == '0)
            side_eff = SIDE_W'(1);
        else if (side_reg > SIDE_W'(MAX_SIDE))
            side_eff = SIDE_W'(MAX_SIDE);
        else
            side_eff = side_reg;
        top_idx = COORD_W'(side_eff - SIDE_W'(1));
    end

    // Classify the word: saturate every coordinate and attach the side in use.
    always_comb
    begin
        push_cmd.mode  = items.mode;
        push_cmd.xl    = clamp(items.x_low, top_idx);
        push_cmd.yl    = clamp(items.y_low, top_idx);
        push_cmd.zl    = clamp(items.z_low, top_idx);
        push_cmd.xh    = clamp(items.x_high, top_idx);
        push_cmd.yh    = clamp(items.y_high, top_idx);
        push_cmd.zh    = clamp(items.z_high, top_idx);
        push_cmd.value = items.add_value;
        push_cmd.side  = side_eff;
    end

    // No word is taken while the store is being cleared.
    assign items.ready = push_ready & ~status.clearing;
    assign push_valid  = items.valid & ~status.clearing;

endmodule
`default_nettype wire

### design/fw3_queue.sv
`default_nettype none
module fw3_queue import fw3_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire cmd_t push_cmd,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output cmd_t      pop_cmd
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    // Two-entry ring of commands.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (do_push && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule
`default_nettype wire

### design/fw3_back.sv
`default_nettype none
module fw3_back import fw3_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    pop_valid,
    output logic         pop_ready,
    input  wire cmd_t    pop_cmd,
    output back_status_t status,
    fw3_out_if.source    results
);

    state_t              state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [2:0]          corner_reg, corner_next;
    logic [ITER_W-1:0]   i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [CELL_W-1:0]   acc_reg, acc_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic                out_valid_reg, out_valid_next;
    logic [CELL_W-1:0]   out_data_reg, out_data_next;

    logic [CELL_W-1:0]   mem [DEPTH];
    logic [CELL_W-1:0]   rd_data_reg;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_addr;
    logic [CELL_W-1:0]   mem_wdata;

    logic [ITER_W-1:0]   sx, sy, sz, ni, nj, nk;
    logic                corner_done;

    // Walk start: an update begins at low; a set query corner bit takes low minus one.
    always_comb
    begin
        if (cmd_reg.mode == MODE_ADD)
        begin
            sx = {2'b00, cmd_reg.xl};
            sy = {2'b00, cmd_reg.yl};
            sz = {2'b00, cmd_reg.zl};
        end
        else
        begin
            sx = corner_reg[0] ? ({2'b00, cmd_reg.xl} - ITER_W'(1)) : {2'b00, cmd_reg.xh};
            sy = corner_reg[1] ? ({2'b00, cmd_reg.yl} - ITER_W'(1)) : {2'b00, cmd_reg.yh};
            sz = corner_reg[2] ? ({2'b00, cmd_reg.zl} - ITER_W'(1)) : {2'b00, cmd_reg.zh};
        end
        ni = (cmd_reg.mode == MODE_ADD) ? next_up(i_reg) : next_down(i_reg);
        nj = (cmd_reg.mode == MODE_ADD) ? next_up(j_reg) : next_down(j_reg);
        nk = (cmd_reg.mode == MODE_ADD) ? next_up(k_reg) : next_down(k_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        corner_reg   <= corner_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        k_reg        <= k_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

    // Cell store: one access per cycle, read data registered.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        rd_data_reg <= mem[mem_addr];
    end

    // Sequencer: clearing pass, then one cell read and one write or accumulate at a time.
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        corner_next    = corner_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        acc_next       = acc_reg;
        clr_next       = clr_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg & ~results.ready;
        pop_ready      = 1'b0;
        mem_we         = 1'b0;
        mem_addr       = {i_reg[COORD_W-1:0], j_reg[COORD_W-1:0], k_reg[COORD_W-1:0]};
        mem_wdata      = rd_data_reg + {{(CELL_W-VALUE_W){cmd_reg.value[VALUE_W-1]}},
                                        cmd_reg.value};
        corner_done    = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    cmd_next    = pop_cmd;
                    corner_next = '0;
                    acc_next    = '0;
                    state_next  = S_SETUP;
                end
            end
            S_SETUP:
            begin
                i_next = sx;
                j_next = sy;
                k_next = sz;
                if (idx_live(sx, cmd_reg.mode, cmd_reg.side)
                    && idx_live(sy, cmd_reg.mode, cmd_reg.side)
                    && idx_live(sz, cmd_reg.mode, cmd_reg.side))
                    state_next = S_RD;
                else
                    corner_done = 1'b1;
            end
            S_RD:
            begin
                state_next = S_WR;
            end
            S_WR:
            begin
                if (cmd_reg.mode == MODE_ADD)
                    mem_we = 1'b1;
                else if (^corner_reg)
                    acc_next = acc_reg - rd_data_reg;
                else
                    acc_next = acc_reg + rd_data_reg;
                state_next = S_RD;
                // Innermost axis first, then carry outwards.
                if (idx_live(nk, cmd_reg.mode, cmd_reg.side))
                    k_next = nk;
                else
                begin
                    k_next = sz;
                    if (idx_live(nj, cmd_reg.mode, cmd_reg.side))
                        j_next = nj;
                    else
                    begin
                        j_next = sy;
                        if (idx_live(ni, cmd_reg.mode, cmd_reg.side))
                            i_next = ni;
                        else
                            corner_done = 1'b1;
                    end
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = acc_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // Finish a corner: an update ends, a query moves on or reports.
        if (corner_done)
        begin
            if (cmd_reg.mode == MODE_ADD)
                state_next = S_IDLE;
            else if (corner_reg == 3'd7)
                state_next = S_OUT;
            else
            begin
                corner_next = corner_reg + 3'd1;
                state_next  = S_SETUP;
            end
        end
    end

    assign status.clearing = (state_reg == S_CLEAR);
    assign results.valid   = out_valid_reg;
    assign results.box_sum = out_data_reg;

    // Nothing leaves the queue during the clearing pass.
    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !(pop_valid && pop_ready))
        else $error("command taken during clearing pass");

    // Cells change only when clearing or updating.
    a_write_kind: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_CLEAR || (state_reg == S_WR && cmd_reg.mode == MODE_ADD)))
        else $error("unexpected cell write");

    // Only queries reach the reporting state.
    a_out_query: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |-> (cmd_reg.mode == MODE_QUERY))
        else $error("update reached result state");

    // A result appears only after the reporting state.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside reporting state");

endmodule
`default_nettype wire

### design/fenwick_3d_point_add_box_sum.sv
`default_nettype none
// Three-dimensional binary indexed tree over a 32 by 32 by 32 cube of 64-bit cells. A word in
// mode 0 adds its signed value at one point and gives no result; a word in mode 1 returns the
// wrapped sum over the inclusive box. After reset the store is swept to zero, one cell per
// cycle, and no word is accepted during the sweep; side length writes are taken at any time.
// Each tree cell visited takes a read and then a write or accumulate on the single memory
// port: an update visits at most log2(side)+1 cells per axis, up to 216 cells at side 32, and
// a query walks eight corner prefixes of at most five cells per axis, up to 1000 cells. A
// short command queue lets the next words be taken while the back works, and the result
// register lets the back continue while a sum waits to be collected.
module fenwick_3d_point_add_box_sum import fw3_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    fw3_in_if.sink    items,
    fw3_cfg_if.sink   cfg,
    fw3_out_if.source results
);

    logic         push_valid, push_ready, pop_valid, pop_ready;
    cmd_t         push_cmd, pop_cmd;
    back_status_t status;

    fw3_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items),
        .cfg        (cfg),
        .status     (status),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    fw3_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    fw3_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .status    (status),
        .results   (results)
    );

endmodule
`default_nettype wire
